// ===== rtl/lru_pkg.sv =====
package lru_pkg;

	// Field widths fixed by the item formats.
	localparam int PAGE_W      = 16;
	localparam int FRAME_IDX_W = 4;
	localparam int CNT_W       = 32;
	localparam int FIU_W       = 5;

	// Frame count default and reset value of the frames-in-use register.
	localparam int          MAX_FRAMES_DEF = 16;
	localparam logic [4:0]  FIU_RESET      = 5'd16;

	// Configuration port geometry: one 32-bit register per word.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_TOUCH,
		ST_DONE
	} state_t;

	// Control from the sequencer to the compare unit.
	typedef struct packed {
		logic clear;
		logic chk;
		logic entry_valid;
	} scan_ctl_t;

	// Status from the compare unit back to the sequencer.
	typedef struct packed {
		logic hit_found;
		logic empty_found;
	} scan_sts_t;

endpackage

// ===== rtl/lru_in_if.sv =====
interface lru_in_if;
	logic                        valid;
	logic                        ready;
	logic [lru_pkg::PAGE_W-1:0]  page;

	modport source (output valid, output page, input ready);
	modport sink (input valid, input page, output ready);
endinterface

// ===== rtl/lru_out_if.sv =====
interface lru_out_if;
	logic                             valid;
	logic                             ready;
	logic                             hit;
	logic [lru_pkg::FRAME_IDX_W-1:0]  frame_index;
	logic                             evicted_valid;
	logic [lru_pkg::PAGE_W-1:0]       evicted_page;
	logic [lru_pkg::CNT_W-1:0]        hit_total;
	logic [lru_pkg::CNT_W-1:0]        fault_total;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output hit_total, output fault_total, input ready);
	modport sink (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input hit_total, input fault_total, output ready);
endinterface

// ===== rtl/lru_ram.sv =====
module lru_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lru_scan.sv =====
module lru_scan #(
	parameter int IDX_W = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lru_pkg::scan_ctl_t          ctl,
	input  logic [lru_pkg::PAGE_W-1:0]  key,
	input  logic [IDX_W-1:0]            idx,
	input  logic [lru_pkg::PAGE_W-1:0]  page_rd,
	input  logic [IDX_W-1:0]            rank_rd,
	output lru_pkg::scan_sts_t          sts,
	output logic [IDX_W-1:0]            hit_idx,
	output logic [IDX_W-1:0]            hit_rank,
	output logic [IDX_W-1:0]            empty_idx,
	output logic [IDX_W-1:0]            empty_rank,
	output logic [IDX_W-1:0]            min_idx,
	output logic [IDX_W-1:0]            min_rank,
	output logic [lru_pkg::PAGE_W-1:0]  min_page
);

	// One frame is examined per cycle; the first match, the first empty
	// frame and the oldest frame are all tracked in the same pass.
	logic hit_found_q;
	logic empty_found_q;
	logic min_any_q;
	logic take_hit;
	logic take_empty;
	logic take_min;

	assign take_hit   = ctl.chk && !hit_found_q && ctl.entry_valid && (page_rd == key);
	assign take_empty = ctl.chk && !empty_found_q && !ctl.entry_valid;
	assign take_min   = ctl.chk && (!min_any_q || (rank_rd < min_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			min_any_q     <= 1'b0;
		end else if (ctl.clear) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			min_any_q     <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_found_q <= 1'b1;
			end
			if (take_empty) begin
				empty_found_q <= 1'b1;
			end
			if (take_min) begin
				min_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx  <= idx;
			hit_rank <= rank_rd;
		end
		if (take_empty) begin
			empty_idx  <= idx;
			empty_rank <= rank_rd;
		end
		if (take_min) begin
			min_idx  <= idx;
			min_rank <= rank_rd;
			min_page <= page_rd;
		end
	end

	assign sts.hit_found   = hit_found_q;
	assign sts.empty_found = empty_found_q;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement engine.
// Each item on page_in carries one referenced page number. Each accepted item
// produces exactly one item on result_out: hit or fault, the frame now holding
// the page, the evicted page (if a filled frame was replaced) and saturating
// hit and fault totals that include this reference.
// Both channels use valid/ready; an item moves on a clock edge where both are
// high. The APB port holds frames_in_use at byte address 0; write it only while
// the engine is idle.
// Operation: with n frames in use, the compare unit walks frames 0..n-1 one per
// cycle through the page and rank memories, the DECIDE state picks the
// frame, then the same memory read port sweeps all MaxFrames ranks to age them,
// and the DONE state loads the output register once it is free. page_in.ready
// is high only when idle, so a new item is taken only after the result of the
// last one is loaded.
// The output register holds a finished result while the receiver stalls; the
// next item is still accepted, and its result waits until the register frees.
// Reset empties every frame, sets the ranks to frame order (frame 0 oldest),
// clears both totals and sets frames_in_use to 16. Ranks are tracked with a
// per-frame written bit, so no clearing pass is needed after reset.
module lru_page_replacement #(
	parameter int MaxFrames = lru_pkg::MAX_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lru_in_if.sink                          page_in,
	lru_out_if.source                       result_out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lru_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lru_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lru_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int IW = $clog2(MaxFrames);
	localparam int CW = IW + 1;

	lru_pkg::state_t state_q;
	lru_pkg::state_t state_d;

	// Configuration register.
	logic [lru_pkg::FIU_W-1:0] fiu_q;
	logic                      reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[lru_pkg::APB_ADDR_W-1:2] == lru_pkg::REG_FRAMES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= lru_pkg::FIU_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			fiu_q <= pwdata[lru_pkg::FIU_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = lru_pkg::APB_DATA_W'(fiu_q);
		end
	end

	// A count of zero behaves as one frame; counts beyond the frame array clamp.
	logic [CW-1:0] n_clamp;

	always_comb begin
		if (fiu_q == '0) begin
			n_clamp = CW'(1);
		end else if (32'(fiu_q) > 32'(MaxFrames)) begin
			n_clamp = CW'(MaxFrames);
		end else begin
			n_clamp = CW'(fiu_q);
		end
	end

	// Sequencer and sweep registers.
	logic [CW-1:0]              n_q;
	logic [lru_pkg::PAGE_W-1:0] key_q;
	logic [CW-1:0]              rd_q;
	logic                       chk_s1;
	logic [IW-1:0]              idx_s1;
	logic [MaxFrames-1:0]       frame_valid_q;
	logic [MaxFrames-1:0]       rank_init_q;

	logic [IW-1:0]              sel_q;
	logic [IW-1:0]              sel_rank_q;
	logic                       hit_q;
	logic                       ev_valid_q;
	logic [lru_pkg::PAGE_W-1:0] ev_page_q;
	logic [lru_pkg::CNT_W-1:0]  hit_cnt_q;
	logic [lru_pkg::CNT_W-1:0]  fault_cnt_q;

	logic                       out_valid_q;
	logic                       accept;
	logic                       sweeping;
	logic [CW-1:0]              limit;
	logic                       issue;
	logic                       out_free;

	assign accept   = page_in.valid && page_in.ready;
	assign sweeping = (state_q == lru_pkg::ST_SCAN) || (state_q == lru_pkg::ST_TOUCH);
	assign limit    = (state_q == lru_pkg::ST_SCAN) ? n_q : CW'(MaxFrames);
	assign issue    = sweeping && (rd_q < limit);
	assign out_free = !out_valid_q || result_out.ready;

	assign page_in.ready = (state_q == lru_pkg::ST_IDLE);

	// Page and rank memories share the sweep address.
	logic [lru_pkg::PAGE_W-1:0] page_rd;
	logic [IW-1:0]              rank_ram;
	logic [IW-1:0]              rank_rd;
	logic                       page_we;
	logic                       rank_we;
	logic [IW-1:0]              rank_wdata;

	// A rank never written since reset still holds its frame index.
	assign rank_rd = rank_init_q[idx_s1] ? rank_ram : idx_s1;

	// Compare unit.
	lru_pkg::scan_ctl_t         scan_ctl;
	lru_pkg::scan_sts_t         scan_sts;
	logic [IW-1:0]              hit_idx;
	logic [IW-1:0]              hit_rank;
	logic [IW-1:0]              empty_idx;
	logic [IW-1:0]              empty_rank;
	logic [IW-1:0]              min_idx;
	logic [IW-1:0]              min_rank;
	logic [lru_pkg::PAGE_W-1:0] min_page;

	assign scan_ctl.clear       = accept;
	assign scan_ctl.chk         = chk_s1 && (state_q == lru_pkg::ST_SCAN);
	assign scan_ctl.entry_valid = frame_valid_q[idx_s1];

	lru_scan #(
		.IDX_W (IW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.key        (key_q),
		.idx        (idx_s1),
		.page_rd    (page_rd),
		.rank_rd    (rank_rd),
		.sts        (scan_sts),
		.hit_idx    (hit_idx),
		.hit_rank   (hit_rank),
		.empty_idx  (empty_idx),
		.empty_rank (empty_rank),
		.min_idx    (min_idx),
		.min_rank   (min_rank),
		.min_page   (min_page)
	);

	// Frame choice: the hit frame, else the lowest empty frame, else the oldest.
	logic [IW-1:0] sel_d;
	logic [IW-1:0] sel_rank_d;

	always_comb begin
		if (scan_sts.hit_found) begin
			sel_d      = hit_idx;
			sel_rank_d = hit_rank;
		end else if (scan_sts.empty_found) begin
			sel_d      = empty_idx;
			sel_rank_d = empty_rank;
		end else begin
			sel_d      = min_idx;
			sel_rank_d = min_rank;
		end
	end

	assign page_we = (state_q == lru_pkg::ST_DECIDE) && !scan_sts.hit_found;

	// Aging: the touched frame becomes newest, newer frames move down by one.
	always_comb begin
		if (idx_s1 == sel_q) begin
			rank_wdata = IW'(MaxFrames - 1);
		end else if (rank_rd > sel_rank_q) begin
			rank_wdata = rank_rd - IW'(1);
		end else begin
			rank_wdata = rank_rd;
		end
	end

	assign rank_we = (state_q == lru_pkg::ST_TOUCH) && chk_s1;

	lru_ram #(
		.WIDTH (lru_pkg::PAGE_W),
		.DEPTH (MaxFrames)
	) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (sel_d),
		.wdata (key_q),
		.raddr (rd_q[IW-1:0]),
		.rdata (page_rd)
	);

	lru_ram #(
		.WIDTH (IW),
		.DEPTH (MaxFrames)
	) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_wdata),
		.raddr (rd_q[IW-1:0]),
		.rdata (rank_ram)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Each sweep ends once the last address has been issued; its final
	// compare or write-back lands on that same edge.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lru_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = lru_pkg::ST_SCAN;
				end
			end
			lru_pkg::ST_SCAN: begin
				if (!issue) begin
					state_d = lru_pkg::ST_DECIDE;
				end
			end
			lru_pkg::ST_DECIDE: begin
				state_d = lru_pkg::ST_TOUCH;
			end
			lru_pkg::ST_TOUCH: begin
				if (!issue) begin
					state_d = lru_pkg::ST_DONE;
				end
			end
			lru_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = lru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lru_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q          <= '0;
			chk_s1        <= 1'b0;
			frame_valid_q <= '0;
			rank_init_q   <= '0;
			hit_cnt_q     <= '0;
			fault_cnt_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			chk_s1 <= issue;
			if (accept || (state_q == lru_pkg::ST_DECIDE)) begin
				rd_q <= '0;
			end else if (issue) begin
				rd_q <= rd_q + CW'(1);
			end
			if (state_q == lru_pkg::ST_DECIDE) begin
				if (scan_sts.hit_found) begin
					if (hit_cnt_q != '1) begin
						hit_cnt_q <= hit_cnt_q + lru_pkg::CNT_W'(1);
					end
				end else begin
					frame_valid_q[sel_d] <= 1'b1;
					if (fault_cnt_q != '1) begin
						fault_cnt_q <= fault_cnt_q + lru_pkg::CNT_W'(1);
					end
				end
			end
			if (rank_we) begin
				rank_init_q[idx_s1] <= 1'b1;
			end
			if ((state_q == lru_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	logic                                hit_out_q;
	logic [lru_pkg::FRAME_IDX_W-1:0]     frame_out_q;
	logic                                ev_valid_out_q;
	logic [lru_pkg::PAGE_W-1:0]          ev_page_out_q;
	logic [lru_pkg::CNT_W-1:0]           hit_tot_out_q;
	logic [lru_pkg::CNT_W-1:0]           fault_tot_out_q;

	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IW-1:0];
		if (accept) begin
			n_q   <= n_clamp;
			key_q <= page_in.page;
		end
		if (state_q == lru_pkg::ST_DECIDE) begin
			sel_q      <= sel_d;
			sel_rank_q <= sel_rank_d;
			hit_q      <= scan_sts.hit_found;
			ev_valid_q <= !scan_sts.hit_found && !scan_sts.empty_found;
			if (!scan_sts.hit_found && !scan_sts.empty_found) begin
				ev_page_q <= min_page;
			end else begin
				ev_page_q <= '0;
			end
		end
		if ((state_q == lru_pkg::ST_DONE) && out_free) begin
			hit_out_q       <= hit_q;
			frame_out_q     <= lru_pkg::FRAME_IDX_W'(sel_q);
			ev_valid_out_q  <= ev_valid_q;
			ev_page_out_q   <= ev_page_q;
			hit_tot_out_q   <= hit_cnt_q;
			fault_tot_out_q <= fault_cnt_q;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.hit           = hit_out_q;
	assign result_out.frame_index   = frame_out_q;
	assign result_out.evicted_valid = ev_valid_out_q;
	assign result_out.evicted_page  = ev_page_out_q;
	assign result_out.hit_total     = hit_tot_out_q;
	assign result_out.fault_total   = fault_tot_out_q;

endmodule
